@@ hdl/dtpf_pkg.sv @@
package dtpf_pkg;

	// Node pool size and the widths that follow from it.
	localparam int NODES       = 4096;
	localparam int NODE_W      = $clog2(NODES);
	localparam int USED_W      = $clog2(NODES + 1);
	localparam int RADIX       = 10;
	localparam int DIGIT_W     = 4;
	localparam int FLAG_W      = RADIX + 1;
	localparam int CHILD_DEPTH = NODES * RADIX;
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

	// Bit 0 of a node's flags marks the end of a number; bits 1..10 mark children.
	localparam int TAIL_BIT = 0;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_END   = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIG_WAIT,
		ST_ALLOC,
		ST_END_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic rd_digit;
		logic rd_end;
		logic dig_resolve;
		logic alloc_clear;
		logic end_resolve;
		logic end_skip;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic digit_go;
		logic can_end;
		logic alloc_need;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/dtpf_channels.sv @@
interface dtpf_in_if;
	import dtpf_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [DIGIT_W-1:0] digit;

	modport source (output valid, kind, digit, input ready);
	modport sink (input valid, kind, digit, output ready);
endinterface

interface dtpf_out_if;
	logic valid;
	logic ready;
	logic number_ok;
	logic list_ok;
	logic pool_full;

	modport source (output valid, number_ok, list_ok, pool_full, input ready);
	modport sink (input valid, number_ok, list_ok, pool_full, output ready);
endinterface

@@ hdl/dtpf_ram.sv @@
module dtpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/dtpf_ctrl.sv @@
module dtpf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_kind,
	output logic            in_ready,
	input  dtpf_pkg::sts_t  sts,
	output dtpf_pkg::cmd_t  cmd
);
	import dtpf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: state_nxt = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						KIND_DIGIT: if (sts.digit_go) state_nxt = ST_DIG_WAIT;
						KIND_END:   state_nxt = sts.can_end ? ST_END_WAIT : ST_EMIT;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_DIG_WAIT: state_nxt = sts.alloc_need ? ST_ALLOC : ST_IDLE;
			ST_ALLOC:    state_nxt = ST_IDLE;
			ST_END_WAIT: state_nxt = ST_EMIT;
			ST_EMIT:     if (sts.out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_INIT: cmd.clear = 1'b1;
			ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						KIND_DIGIT: cmd.rd_digit = sts.digit_go;
						KIND_END: begin
							cmd.rd_end   = sts.can_end;
							cmd.end_skip = !sts.can_end;
						end
						KIND_START: cmd.clear = 1'b1;
						default:    cmd = '0;
					endcase
				end
			end
			ST_DIG_WAIT: cmd.dig_resolve = 1'b1;
			ST_ALLOC:    cmd.alloc_clear = 1'b1;
			ST_END_WAIT: cmd.end_resolve = 1'b1;
			ST_EMIT:     cmd.emit = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

@@ hdl/dtpf_datapath.sv @@
module dtpf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtpf_pkg::cmd_t                cmd,
	output dtpf_pkg::sts_t                sts,
	input  logic [dtpf_pkg::DIGIT_W-1:0]  in_digit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_number_ok,
	output logic                          out_list_ok,
	output logic                          out_pool_full
);
	import dtpf_pkg::*;

	logic [NODE_W-1:0]   cur_q;
	logic [USED_W-1:0]   used_q;
	logic                good_q;
	logic                failed_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic [CHILD_AW-1:0] caddr_q;
	logic                ok_q;
	logic                number_ok_q;
	logic                list_ok_q;
	logic                pool_full_q;

	logic                f_we;
	logic [NODE_W-1:0]   f_waddr;
	logic [FLAG_W-1:0]   f_wdata;
	logic                f_re;
	logic [FLAG_W-1:0]   f_rdata;
	logic                c_we;
	logic [CHILD_AW-1:0] c_addr;
	logic [NODE_W-1:0]   c_rdata;

	logic [FLAG_W-1:0]   child_mask;
	logic                tail;
	logic                hit;
	logic                full;
	logic                alloc;
	logic                end_ok;

	assign c_addr     = CHILD_AW'(cur_q) * CHILD_AW'(RADIX) + CHILD_AW'(in_digit);
	assign child_mask = FLAG_W'(2) << digit_q;
	assign tail       = f_rdata[TAIL_BIT];
	assign hit        = |(f_rdata & child_mask);
	assign full       = (used_q >= USED_W'(NODES));
	assign alloc      = !tail && !hit && !full;
	assign end_ok     = (f_rdata == '0);
	assign f_re       = cmd.rd_digit || cmd.rd_end;
	assign c_we       = cmd.dig_resolve && alloc;

	assign sts.digit_go   = (in_digit < DIGIT_W'(RADIX)) && good_q && !failed_q;
	assign sts.can_end    = good_q && !failed_q;
	assign sts.alloc_need = alloc;
	assign sts.out_free   = !out_valid_q || out_ready;

	// One write to the flag store per cycle; the commands that write are never
	// issued together.
	always_comb begin
		f_we    = 1'b0;
		f_waddr = cur_q;
		f_wdata = '0;
		if (cmd.clear) begin
			f_we    = 1'b1;
			f_waddr = '0;
		end else if (cmd.dig_resolve && alloc) begin
			f_we    = 1'b1;
			f_wdata = f_rdata | child_mask;
		end else if (cmd.alloc_clear) begin
			f_we    = 1'b1;
		end else if (cmd.end_resolve && end_ok) begin
			f_we             = 1'b1;
			f_wdata[TAIL_BIT] = 1'b1;
		end
	end

	dtpf_ram #(.WIDTH(FLAG_W), .DEPTH(NODES)) u_flags (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (cur_q),
		.rdata (f_rdata)
	);

	dtpf_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
		.clk   (clk),
		.we    (c_we),
		.waddr (caddr_q),
		.wdata (used_q[NODE_W-1:0]),
		.re    (cmd.rd_digit),
		.raddr (c_addr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			used_q      <= USED_W'(1);
			good_q      <= 1'b1;
			failed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cur_q    <= '0;
				used_q   <= USED_W'(1);
				good_q   <= 1'b1;
				failed_q <= 1'b0;
				ovf_q    <= 1'b0;
			end
			if (cmd.dig_resolve) begin
				if (tail) begin
					failed_q <= 1'b1;
				end else if (hit) begin
					cur_q <= c_rdata;
				end else if (full) begin
					ovf_q    <= 1'b1;
					failed_q <= 1'b1;
				end else begin
					cur_q  <= used_q[NODE_W-1:0];
					used_q <= used_q + USED_W'(1);
				end
			end
			if (cmd.end_resolve || cmd.end_skip) begin
				good_q   <= good_q && cmd.end_resolve && end_ok;
				cur_q    <= '0;
				failed_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_digit) begin
			digit_q <= in_digit;
			caddr_q <= c_addr;
		end
		if (cmd.end_resolve || cmd.end_skip) begin
			ok_q <= cmd.end_resolve && end_ok;
		end
		if (cmd.emit) begin
			number_ok_q <= ok_q;
			list_ok_q   <= good_q;
			pool_full_q <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_number_ok = number_ok_q;
	assign out_list_ok   = list_ok_q;
	assign out_pool_full = pool_full_q;

endmodule

@@ hdl/digit_trie_prefix_free_checker.sv @@
// Prefix-free check of a list of decimal numbers, built on a ten-way trie.
// Requests arrive on the items channel: a digit of the current number, the
// end of a number, or the start of a new list. Each end request produces one
// response on the results channel with number_ok, list_ok and pool_full;
// digit and start requests produce none.
// A digit needs one registered read of the node flags and child pointer
// memories and then the write-back; allocating a new node adds a step that
// clears its flags, because the flag memory has a single write port.
// An end request is checked in a wait state and then emitted, or emitted
// directly when the number is skipped, as long as the output register is free; a
// start request clears the list on acceptance. Items are taken one at a time.
// After reset the block clears the root node entry in an init state and
// then accepts requests. Reset empties the trie and sets the list as good.
// The response sits in an output register, so the next request is accepted
// while it waits. If the receiver stalls and a second end request finishes,
// the block holds that response internally and accepts no further request
// until the output register frees up.
module digit_trie_prefix_free_checker (
	input logic       clk,
	input logic       arst_n,
	dtpf_in_if.sink   items,
	dtpf_out_if.source results
);
	import dtpf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences each request; the datapath owns the trie memories
	// and the per-list state.
	dtpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (items.kind),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtpf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_digit      (items.digit),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_number_ok (results.number_ok),
		.out_list_ok   (results.list_ok),
		.out_pool_full (results.pool_full)
	);

	// An end request always leaves the block busy in the cycle after it is accepted.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.kind == KIND_END |=> !items.ready)
		else $error("end request did not occupy the block");

	// A start request completes in its own cycle.
	a_start_quick: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.kind == KIND_START |=> items.ready)
		else $error("start request did not complete in one cycle");

	// A number can only be accepted while the list is still prefix-free.
	a_ok_implies_list: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.number_ok |-> results.list_ok)
		else $error("number accepted in a failed list");

	// An allocation is only requested when the pool still has room.
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_clear |-> $past(cmd.dig_resolve) && $past(sts.alloc_need))
		else $error("node clear without a preceding allocation");

endmodule
